// ----- sv/pin_function_controller_assert.svh -----
// Assertion macros for the pin function controller.
`ifndef PIN_FUNCTION_CONTROLLER_ASSERT_SVH
`define PIN_FUNCTION_CONTROLLER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define PFC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/pfc_pkg.sv -----
// Shared types, codes and tables of the pin function controller.
package pfc_pkg;

	localparam logic [2:0] KIND_READ     = 3'd0;
	localparam logic [2:0] KIND_SET_LAT  = 3'd1;
	localparam logic [2:0] KIND_MAKE_IN  = 3'd2;
	localparam logic [2:0] KIND_MAKE_OUT = 3'd3;
	localparam logic [2:0] KIND_ASSIGN   = 3'd4;
	localparam logic [2:0] KIND_BIDIR    = 3'd5;

	localparam logic [1:0] DIR_OUT  = 2'd0;
	localparam logic [1:0] DIR_IN   = 2'd1;
	localparam logic [1:0] DIR_IP   = 2'd2;
	localparam logic [1:0] DIR_DIFF = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	localparam logic [3:0] MODE_MAX = 4'd8;

	localparam int FLD_SEL_A  = 0;
	localparam int FLD_SEL_B  = 1;
	localparam int FLD_SEL_C  = 2;
	localparam int FLD_SEL_D  = 3;
	localparam int FLD_DIR    = 4;
	localparam int FLD_IBUF   = 5;
	localparam int FLD_BIDIR  = 6;
	localparam int FLD_IP     = 7;
	localparam int FLD_LATCH  = 8;
	localparam int NUM_FIELDS = 9;

	typedef struct packed {
		logic       latch_level;
		logic       ip_drives;
		logic       bidir_on;
		logic       in_buffer;
		logic       dir_input;
		logic [3:0] mode_bits;
		logic [3:0] bit_index;
		logic [3:0] port_index;
		logic       read_level;
		logic [1:0] status;
	} pfc_result_t;

	function automatic int port_width(input int idx);
		int w;
		case (idx)
			0:       w = 6;
			1:       w = 16;
			2:       w = 16;
			3:       w = 16;
			4:       w = 16;
			5:       w = 11;
			6:       w = 16;
			7:       w = 16;
			8:       w = 16;
			9:       w = 8;
			10:      w = 16;
			11:      w = 16;
			default: w = 0;
		endcase
		return w;
	endfunction

	function automatic int clamped_width(input int idx, input int port_bits);
		int w;
		w = port_width(idx);
		return (w > port_bits) ? port_bits : w;
	endfunction

	function automatic int port_start(input int idx, input int port_bits);
		int s;
		s = 0;
		for (int j = 0; j < idx; j++) begin
			s += clamped_width(j, port_bits);
		end
		return s;
	endfunction

	function automatic logic [3:0] mode_sel(input logic [3:0] mode);
		logic [3:0] m;
		case (mode)
			4'd0:    m = 4'h0;
			4'd1:    m = 4'h1;
			4'd2:    m = 4'h3;
			4'd3:    m = 4'h5;
			4'd4:    m = 4'h7;
			4'd5:    m = 4'h9;
			4'd6:    m = 4'hB;
			4'd7:    m = 4'hD;
			4'd8:    m = 4'hF;
			default: m = 4'h0;
		endcase
		return m;
	endfunction

endpackage

// ----- sv/pfc_decode.sv -----
// Flat pin number to port and bit decoder over the fixed width table.
module pfc_decode import pfc_pkg::*; #(
	parameter int NUM_PORTS = 12,
	parameter int PORT_BITS = 16,
	parameter int NUM_PINS  = 169,
	parameter int PW        = 4,
	parameter int BW        = 4
) (
	input  logic [7:0]    pin,
	output logic          in_range,
	output logic [PW-1:0] port_idx,
	output logic [BW-1:0] bit_idx
);

	logic [NUM_PORTS-1:0] hit;
	logic [BW-1:0]        off [NUM_PORTS];

	for (genvar i = 0; i < NUM_PORTS; i++) begin : g_port
		localparam int Start = port_start(i, PORT_BITS);
		localparam int Width = clamped_width(i, PORT_BITS);
		assign hit[i] = (32'(pin) >= Start) && (32'(pin) < Start + Width)
			&& (32'(pin) < NUM_PINS);
		assign off[i] = BW'(32'(pin) - Start);
	end

	always_comb begin
		port_idx = '0;
		bit_idx  = '0;
		for (int i = 0; i < NUM_PORTS; i++) begin
			if (hit[i]) begin
				port_idx = PW'(i);
				bit_idx  = off[i];
			end
		end
		in_range = |hit;
	end

endmodule

// ----- sv/pfc_regfile.sv -----
// Per-port register memory with valid bits and write forwarding.
module pfc_regfile import pfc_pkg::*; #(
	parameter int NUM_PORTS = 12,
	parameter int PORT_BITS = 16,
	parameter int PW        = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [PW-1:0]                   rd_port,
	input  logic                            wr_en,
	input  logic [PW-1:0]                   wr_port,
	input  logic [NUM_FIELDS*PORT_BITS-1:0] wr_data,
	output logic [NUM_FIELDS*PORT_BITS-1:0] cur_word
);

	localparam int WordW = NUM_FIELDS * PORT_BITS;

	logic [WordW-1:0]     mem [NUM_PORTS];
	logic [NUM_PORTS-1:0] vld_q;
	logic [WordW-1:0]     rd_data_s1;
	logic                 rd_vld_s1;
	logic [PW-1:0]        rd_port_s1;
	logic                 wr_vld_q;
	logic [PW-1:0]        wr_port_q;
	logic [WordW-1:0]     wr_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_port] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_port];
		end
		if (wr_en) begin
			wr_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_port_s1 <= '0;
			wr_vld_q   <= 1'b0;
			wr_port_q  <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_port] <= 1'b1;
				wr_vld_q       <= 1'b1;
				wr_port_q      <= wr_port;
			end
			if (rd_en) begin
				rd_vld_s1  <= vld_q[rd_port];
				rd_port_s1 <= rd_port;
			end
		end
	end

	always_comb begin
		if (wr_vld_q && (wr_port_q == rd_port_s1)) begin
			cur_word = wr_data_q;
		end else if (rd_vld_s1) begin
			cur_word = rd_data_s1;
		end else begin
			cur_word = '0;
		end
	end

endmodule

// ----- sv/pfc_update.sv -----
// Request decode and single-bit modify of one port word, with result build.
module pfc_update import pfc_pkg::*; #(
	parameter int PORT_BITS = 16,
	parameter int PW        = 4,
	parameter int BW        = 4
) (
	input  logic [2:0]                      kind,
	input  logic                            level_or_enable,
	input  logic [3:0]                      func_mode,
	input  logic [1:0]                      direction,
	input  logic                            pad_level,
	input  logic                            in_range,
	input  logic [PW-1:0]                   port_idx,
	input  logic [BW-1:0]                   bit_idx,
	input  logic [NUM_FIELDS*PORT_BITS-1:0] old_word,
	output logic [NUM_FIELDS*PORT_BITS-1:0] new_word,
	output pfc_result_t                     result
);

	logic [NUM_FIELDS-1:0] cur;
	logic [NUM_FIELDS-1:0] we;
	logic [NUM_FIELDS-1:0] val;
	logic [NUM_FIELDS-1:0] nxt;
	logic [3:0]            msel;
	logic                  port0;
	logic [1:0]            status;
	logic                  rd;

	always_comb begin
		port0 = (port_idx == '0);
		msel  = mode_sel(func_mode);
		for (int f = 0; f < NUM_FIELDS; f++) begin
			cur[f] = old_word[f*PORT_BITS + int'(bit_idx)];
		end
		we     = '0;
		val    = '0;
		status = ST_DONE;
		rd     = 1'b0;
		unique case (kind)
			KIND_READ: begin
				rd = pad_level;
			end
			KIND_SET_LAT: begin
				if (port0) begin
					status = ST_REFUSED;
				end else begin
					we[FLD_LATCH]  = 1'b1;
					val[FLD_LATCH] = level_or_enable;
				end
			end
			KIND_MAKE_IN: begin
				we[FLD_DIR]   = 1'b1;
				val[FLD_DIR]  = 1'b1;
				we[FLD_IBUF]  = 1'b1;
				val[FLD_IBUF] = 1'b1;
			end
			KIND_MAKE_OUT: begin
				if (port0) begin
					status = ST_REFUSED;
				end else begin
					we[FLD_LATCH]  = 1'b1;
					val[FLD_LATCH] = level_or_enable;
					we[FLD_DIR]    = 1'b1;
					we[FLD_IBUF]   = 1'b1;
				end
			end
			KIND_ASSIGN: begin
				if (port0) begin
					status = ST_REFUSED;
				end else begin
					we[FLD_IP]  = 1'b1;
					val[FLD_IP] = (direction == DIR_IP);
				end
				if (direction != DIR_IP) begin
					if (port0 && (direction != DIR_IN)) begin
						status = ST_REFUSED;
					end else begin
						we[FLD_DIR]   = 1'b1;
						val[FLD_DIR]  = (direction != DIR_OUT);
						we[FLD_IBUF]  = 1'b1;
						val[FLD_IBUF] = (direction == DIR_IN);
					end
				end
				if (func_mode <= MODE_MAX) begin
					we[FLD_SEL_A]  = 1'b1;
					val[FLD_SEL_A] = msel[0];
					if (!port0) begin
						we[FLD_SEL_B]  = 1'b1;
						val[FLD_SEL_B] = msel[1];
						we[FLD_SEL_C]  = 1'b1;
						val[FLD_SEL_C] = msel[2];
						we[FLD_SEL_D]  = 1'b1;
						val[FLD_SEL_D] = msel[3];
					end
				end
			end
			KIND_BIDIR: begin
				if (port0) begin
					status = ST_REFUSED;
				end else begin
					we[FLD_BIDIR]  = 1'b1;
					val[FLD_BIDIR] = level_or_enable;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
		nxt      = (we & val) | (~we & cur);
		new_word = old_word;
		for (int f = 0; f < NUM_FIELDS; f++) begin
			new_word[f*PORT_BITS + int'(bit_idx)] = nxt[f];
		end

		result = '0;
		if (!in_range) begin
			result.status = ST_RANGE;
		end else begin
			result.status      = status;
			result.read_level  = rd;
			result.port_index  = 4'(port_idx);
			result.bit_index   = 4'(bit_idx);
			result.mode_bits   = {nxt[FLD_SEL_D], nxt[FLD_SEL_C], nxt[FLD_SEL_B],
				nxt[FLD_SEL_A]};
			result.dir_input   = nxt[FLD_DIR];
			result.in_buffer   = nxt[FLD_IBUF];
			result.bidir_on    = nxt[FLD_BIDIR];
			result.ip_drives   = nxt[FLD_IP];
			result.latch_level = nxt[FLD_LATCH];
		end
	end

endmodule

// ----- sv/pin_function_controller.sv -----
// Pin multiplexing and GPIO controller top level.
//
// Requests enter on the s_ channel: s_tuser carries the request kind and
// s_tdata the pin number, level or enable, function mode, direction and the
// sampled pad level. Each request yields exactly one result word on the m_
// channel: status, read level, decoded port and bit, and the pin's bits
// after the request.
// The pin decode and the read of the port's word from the register memory
// happen in the accept cycle; the modify stage then modifies one bit per
// register field, writes the word back for an in-range pin and loads the
// output register. A result shows on m_tvalid once its request has passed
// the modify-stage and output registers, and requests are taken one per cycle
// while the output is not stalled: the memory has one read and one write port
// and a write followed by a read of the same port is forwarded from the last-write register.
// Reset clears the valid bit of every memory entry, so all pins read as
// port mode, output direction, all bits zero; no clearing pass is needed.
// When m_tready is low the result is held, the request behind it waits in
// the modify stage, and s_tready drops once both are full.
module pin_function_controller import pfc_pkg::*; #(
	parameter int NUM_PORTS = 12,
	parameter int PORT_BITS = 16,
	parameter int NUM_PINS  = 169
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pin[7:0], level_or_enable[8], func_mode[12:9], direction[14:13], pad_level[15]
	input  logic [15:0] s_tdata,
	// kind[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], read_level[2], port_index[6:3], bit_index[10:7], mode_bits[14:11],
	// dir_input[15], in_buffer[16], bidir_on[17], ip_drives[18], latch_level[19], zero[23:20]
	output logic [23:0] m_tdata
);

	localparam int PW    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int BW    = $clog2(PORT_BITS);
	localparam int WordW = NUM_FIELDS * PORT_BITS;

	logic          s_acc;
	logic          s1_adv;
	logic          dec_inr;
	logic [PW-1:0] dec_port;
	logic [BW-1:0] dec_bit;

	logic          s1_vld_q;
	logic [2:0]    kind_s1;
	logic          lev_s1;
	logic [3:0]    mode_s1;
	logic [1:0]    dir_s1;
	logic          pad_s1;
	logic          inr_s1;
	logic [PW-1:0] port_s1;
	logic [BW-1:0] bit_s1;

	logic [WordW-1:0] cur_word;
	logic [WordW-1:0] new_word;
	logic             wr_en;
	pfc_result_t      res;
	pfc_result_t      res_q;
	logic             m_tvalid_q;

	assign s1_adv   = s1_vld_q && (!m_tvalid_q || m_tready);
	assign s_tready = !s1_vld_q || s1_adv;
	assign s_acc    = s_tvalid && s_tready;
	assign wr_en    = s1_adv && inr_s1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, res_q};

	pfc_decode #(
		.NUM_PORTS (NUM_PORTS),
		.PORT_BITS (PORT_BITS),
		.NUM_PINS  (NUM_PINS),
		.PW        (PW),
		.BW        (BW)
	) u_decode (
		.pin      (s_tdata[7:0]),
		.in_range (dec_inr),
		.port_idx (dec_port),
		.bit_idx  (dec_bit)
	);

	pfc_regfile #(
		.NUM_PORTS (NUM_PORTS),
		.PORT_BITS (PORT_BITS),
		.PW        (PW)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (s_acc),
		.rd_port  (dec_port),
		.wr_en    (wr_en),
		.wr_port  (port_s1),
		.wr_data  (new_word),
		.cur_word (cur_word)
	);

	pfc_update #(
		.PORT_BITS (PORT_BITS),
		.PW        (PW),
		.BW        (BW)
	) u_update (
		.kind            (kind_s1),
		.level_or_enable (lev_s1),
		.func_mode       (mode_s1),
		.direction       (dir_s1),
		.pad_level       (pad_s1),
		.in_range        (inr_s1),
		.port_idx        (port_s1),
		.bit_idx         (bit_s1),
		.old_word        (cur_word),
		.new_word        (new_word),
		.result          (res)
	);

	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_s1 <= s_tuser;
			lev_s1  <= s_tdata[8];
			mode_s1 <= s_tdata[12:9];
			dir_s1  <= s_tdata[14:13];
			pad_s1  <= s_tdata[15];
			inr_s1  <= dec_inr;
			bit_s1  <= dec_bit;
		end
		if (s1_adv) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q   <= 1'b0;
			port_s1    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				s1_vld_q <= 1'b1;
				port_s1  <= dec_port;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`include "pin_function_controller_assert.svh"

	`PFC_ASSERT_SAME(a_wr_only_on_advance, wr_en, s1_vld_q && (!m_tvalid_q || m_tready), "write back without stage advance")
	`PFC_ASSERT_NEXT(a_stall_holds_stage, s1_vld_q && !s1_adv, s1_vld_q && $stable(port_s1), "stalled stage lost its request")
	`PFC_ASSERT_SAME(a_port0_input_only, m_tvalid_q && (res_q.port_index == 4'd0), (res_q.latch_level == 1'b0) && (res_q.bidir_on == 1'b0) && (res_q.ip_drives == 1'b0) && (res_q.mode_bits[3:1] == 3'b000), "forbidden bit set on input-only port")

endmodule
